>>> hw/rtl/swg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swg_pkg
// Shared types and constants of the substitution word generator: sizes,
// datapath operations, jump conditions, control word and status flags.
// ----------------------------------------------------------------------------
package swg_pkg;

  localparam int unsigned StackDepth     = 64;
  localparam int unsigned StackAw        = $clog2(StackDepth);
  localparam int unsigned SpW            = $clog2(StackDepth + 1);
  localparam int unsigned MaxLetters     = 64;
  localparam int unsigned BufAw          = $clog2(MaxLetters);
  localparam int unsigned CntW           = 7;
  localparam int unsigned RuleW          = 20;
  localparam int unsigned EntryW         = 5;
  localparam int unsigned MaxImageLength = 8;
  localparam int unsigned SlotCount      = 8;
  localparam int unsigned LenCap         = (MaxImageLength < SlotCount) ?
                                           MaxImageLength : SlotCount;
  localparam int unsigned PcW            = 4;

  // configuration register indexes
  localparam logic [2:0] CfgFirstLetter = 3'd0;
  localparam logic [2:0] CfgRuleZero    = 3'd1;
  localparam logic [2:0] CfgRuleOne     = 3'd2;
  localparam logic [2:0] CfgRuleTwo     = 3'd3;
  localparam logic [2:0] CfgRuleThree   = 3'd4;

  typedef enum logic [3:0] {
    OpNop,
    OpAccept,
    OpFirst,
    OpEmit,
    OpPop,
    OpLoad,
    OpRoot,
    OpPush,
    OpDrainInit,
    OpDrain
  } op_e;

  typedef enum logic [3:0] {
    CondNone,
    CondAlways,
    CondNoGo,
    CondGenDone,
    CondNoRun,
    CondRunMore,
    CondPopDone,
    CondRootSkip,
    CondLevelZero,
    CondLevelMore,
    CondDrainStay
  } cond_e;

  typedef struct packed {
    op_e              op;
    cond_e            cond;
    logic [PcW-1:0]   target;
  } ucode_t;

  typedef struct packed {
    logic no_go;
    logic gen_done;
    logic no_run;
    logic run_more;
    logic pop_done;
    logic root_skip;
    logic level_zero;
    logic level_more;
    logic drain_stay;
  } flags_t;

endpackage

>>> hw/rtl/substitution_word_generator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// substitution_word_generator
// Emits the fixed-point word of a four-letter substitution, a requested
// number of letters at a time, by a depth-first walk of the substitution tree.
//
// Usage: program first_letter and the four letter images on the cfg port
// while idle. Each slave beat carries a letter count (0 is dropped, counts
// above 64 give 64). The block first generates the letters into a buffer
// while walking the tree with a 64-entry stack, then drains them as master
// beats; tlast marks the final letter and the overflow bit is the sticky
// stack overflow flag as it stands at the end of the request.
// Sequencing: the single microcode sequencer steps the datapath, one
// operation per step, through letter generation (emits, stack pops, pushes
// and image-run checks) and then the delivery of the letters. The next
// request is taken after the last beat is loaded into the output register,
// by way of the end step back to the idle step.
// A stalled receiver holds the output register and pauses the drain only.
// Reset clears the walk (started off, index one, empty stack, flag clear)
// and all configuration registers to zero.
// ----------------------------------------------------------------------------
module substitution_word_generator (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [7:0]                s_axis_tdata,   // letter_count[6:0]
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [7:0]                m_axis_tdata,   // letter[1:0], overflow[2]
  output logic                      m_axis_tlast,
  input  logic                      cfg_we_i,
  input  logic [2:0]                cfg_index_i,
  input  logic [swg_pkg::RuleW-1:0] cfg_data_i
);

  swg_pkg::op_e    op;
  swg_pkg::flags_t flags;

  swg_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .flags_i (flags),
    .op_o    (op)
  );

  swg_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .op_i          (op),
    .flags_o       (flags),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

endmodule

>>> hw/rtl/swg_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swg_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module swg_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/swg_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swg_seq
// Microcode sequencer: step counter, control store and conditional jumps.
// Each step issues one datapath operation and may jump, unconditionally or on a status flag.
// ----------------------------------------------------------------------------
module swg_seq (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  swg_pkg::flags_t flags_i,
  output swg_pkg::op_e    op_o
);

  localparam logic [swg_pkg::PcW-1:0] StIdle      = 4'd0;
  localparam logic [swg_pkg::PcW-1:0] StFirst     = 4'd1;
  localparam logic [swg_pkg::PcW-1:0] StCheck     = 4'd2;
  localparam logic [swg_pkg::PcW-1:0] StRun       = 4'd3;
  localparam logic [swg_pkg::PcW-1:0] StEmit      = 4'd4;
  localparam logic [swg_pkg::PcW-1:0] StPopChk    = 4'd5;
  localparam logic [swg_pkg::PcW-1:0] StPop       = 4'd6;
  localparam logic [swg_pkg::PcW-1:0] StLoad      = 4'd7;
  localparam logic [swg_pkg::PcW-1:0] StRoot      = 4'd8;
  localparam logic [swg_pkg::PcW-1:0] StRootSet   = 4'd9;
  localparam logic [swg_pkg::PcW-1:0] StPushChk   = 4'd10;
  localparam logic [swg_pkg::PcW-1:0] StPush      = 4'd11;
  localparam logic [swg_pkg::PcW-1:0] StBack      = 4'd12;
  localparam logic [swg_pkg::PcW-1:0] StDrainInit = 4'd13;
  localparam logic [swg_pkg::PcW-1:0] StDrain     = 4'd14;
  localparam logic [swg_pkg::PcW-1:0] StEnd       = 4'd15;

  function automatic swg_pkg::ucode_t ucode(input logic [swg_pkg::PcW-1:0] pc);
    swg_pkg::ucode_t w;
    w = '{op: swg_pkg::OpNop, cond: swg_pkg::CondNone, target: StIdle};
    unique case (pc)
      StIdle:      w = '{swg_pkg::OpAccept,    swg_pkg::CondNoGo,      StIdle};
      StFirst:     w = '{swg_pkg::OpFirst,     swg_pkg::CondNone,      StIdle};
      StCheck:     w = '{swg_pkg::OpNop,       swg_pkg::CondGenDone,   StDrainInit};
      StRun:       w = '{swg_pkg::OpNop,       swg_pkg::CondNoRun,     StPopChk};
      StEmit:      w = '{swg_pkg::OpEmit,      swg_pkg::CondRunMore,   StEmit};
      StPopChk:    w = '{swg_pkg::OpNop,       swg_pkg::CondPopDone,   StRoot};
      StPop:       w = '{swg_pkg::OpPop,       swg_pkg::CondNone,      StIdle};
      StLoad:      w = '{swg_pkg::OpLoad,      swg_pkg::CondAlways,    StPopChk};
      StRoot:      w = '{swg_pkg::OpNop,       swg_pkg::CondRootSkip,  StPushChk};
      StRootSet:   w = '{swg_pkg::OpRoot,      swg_pkg::CondNone,      StIdle};
      StPushChk:   w = '{swg_pkg::OpNop,       swg_pkg::CondLevelZero, StCheck};
      StPush:      w = '{swg_pkg::OpPush,      swg_pkg::CondLevelMore, StPush};
      StBack:      w = '{swg_pkg::OpNop,       swg_pkg::CondAlways,    StCheck};
      StDrainInit: w = '{swg_pkg::OpDrainInit, swg_pkg::CondNone,      StIdle};
      StDrain:     w = '{swg_pkg::OpDrain,     swg_pkg::CondDrainStay, StDrain};
      StEnd:       w = '{swg_pkg::OpNop,       swg_pkg::CondAlways,    StIdle};
    endcase
    return w;
  endfunction

  logic [swg_pkg::PcW-1:0] pc_q, pc_d;
  swg_pkg::ucode_t         uc;
  logic                    take;

  assign uc = ucode(pc_q);

  always_comb begin
    unique case (uc.cond)
      swg_pkg::CondNone:      take = 1'b0;
      swg_pkg::CondAlways:    take = 1'b1;
      swg_pkg::CondNoGo:      take = flags_i.no_go;
      swg_pkg::CondGenDone:   take = flags_i.gen_done;
      swg_pkg::CondNoRun:     take = flags_i.no_run;
      swg_pkg::CondRunMore:   take = flags_i.run_more;
      swg_pkg::CondPopDone:   take = flags_i.pop_done;
      swg_pkg::CondRootSkip:  take = flags_i.root_skip;
      swg_pkg::CondLevelZero: take = flags_i.level_zero;
      swg_pkg::CondLevelMore: take = flags_i.level_more;
      swg_pkg::CondDrainStay: take = flags_i.drain_stay;
      default:                take = 1'b0;
    endcase
    pc_d = take ? uc.target : pc_q + 4'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= StIdle;
    end else begin
      pc_q <= pc_d;
    end
  end

  assign op_o = uc.op;

endmodule

>>> hw/rtl/swg_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swg_dp
// Datapath of the word generator: walk registers, walk stack and letter
// buffer memories, configuration registers and the output register.
// ----------------------------------------------------------------------------
module swg_dp (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  swg_pkg::op_e               op_i,
  output swg_pkg::flags_t            flags_o,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [7:0]                 s_axis_tdata,
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [7:0]                 m_axis_tdata,
  output logic                       m_axis_tlast,
  input  logic                       cfg_we_i,
  input  logic [2:0]                 cfg_index_i,
  input  logic [swg_pkg::RuleW-1:0]  cfg_data_i
);

  localparam logic [swg_pkg::CntW-1:0] CntMax   = swg_pkg::CntW'(swg_pkg::MaxLetters);
  localparam logic [swg_pkg::SpW-1:0]  SpFull   = swg_pkg::SpW'(swg_pkg::StackDepth);
  localparam logic [4:0]               LenLimit = 5'(swg_pkg::LenCap);

  logic [1:0]                first_q, first_d;
  logic [swg_pkg::RuleW-1:0] rules_q [4];
  logic [swg_pkg::RuleW-1:0] rules_d [4];
  logic                      started_q, started_d;
  logic [1:0]                a_q, a_d;
  logic [3:0]                i_q, i_d;
  logic [swg_pkg::SpW-1:0]   sp_q, sp_d;
  logic [swg_pkg::SpW-1:0]   lvl_q, lvl_d;
  logic                      ovf_q, ovf_d;
  logic [swg_pkg::CntW-1:0]  cnt_q, cnt_d;
  logic [swg_pkg::CntW-1:0]  gen_q, gen_d;
  logic [swg_pkg::CntW-1:0]  k_q, k_d;
  logic                      out_valid_q, out_valid_d;
  logic [1:0]                out_letter_q, out_letter_d;
  logic                      out_last_q, out_last_d;
  logic                      out_ovf_q, out_ovf_d;

  logic [swg_pkg::RuleW-1:0] rule_cur;
  logic [4:0]                len_raw;
  logic [3:0]                len_cur;
  logic [1:0]                img_letter;
  logic                      i_ge_len;
  logic [swg_pkg::CntW-1:0]  count_in, count_sat;
  logic [swg_pkg::CntW-1:0]  gen_inc, k_inc;
  logic [3:0]                i_inc;
  logic [swg_pkg::SpW-1:0]   sp_dec;
  logic                      drain_load;

  logic                            stk_we;
  logic [swg_pkg::EntryW-1:0]      stk_wdata, stk_rdata;
  logic                            buf_we;
  logic [1:0]                      buf_wdata, buf_rdata;
  logic [swg_pkg::BufAw-1:0]       buf_raddr;

  // current node image
  assign rule_cur   = rules_q[a_q];
  assign len_raw    = {1'b0, rule_cur[19:16]} + 5'd1;
  assign len_cur    = (len_raw > LenLimit) ? LenLimit[3:0] : len_raw[3:0];
  assign img_letter = rule_cur[{i_q[2:0], 1'b0} +: 2];
  assign i_ge_len   = (i_q >= len_cur);

  assign count_in  = s_axis_tdata[swg_pkg::CntW-1:0];
  assign count_sat = (count_in > CntMax) ? CntMax : count_in;
  assign gen_inc   = gen_q + 7'd1;
  assign k_inc     = k_q + 7'd1;
  assign i_inc     = i_q + 4'd1;
  assign sp_dec    = sp_q - 7'd1;

  assign drain_load = (op_i == swg_pkg::OpDrain) && (!out_valid_q || m_axis_tready);

  always_comb begin
    flags_o.no_go      = !s_axis_tvalid || (count_in == '0);
    flags_o.gen_done   = (gen_q >= cnt_q);
    flags_o.no_run     = i_ge_len;
    flags_o.run_more   = (i_inc < len_cur) && (gen_inc < cnt_q);
    flags_o.pop_done   = !((sp_q != '0) && i_ge_len);
    flags_o.root_skip  = !((sp_q == '0) && i_ge_len);
    flags_o.level_zero = (lvl_q == '0);
    flags_o.level_more = (lvl_q > 7'd1);
    flags_o.drain_stay = !(drain_load && (k_inc == cnt_q));
  end

  assign s_axis_tready = (op_i == swg_pkg::OpAccept);

  // memory ports
  assign stk_we    = (op_i == swg_pkg::OpPush) && (sp_q < SpFull);
  assign stk_wdata = {i_q[2:0], a_q};
  assign buf_we    = ((op_i == swg_pkg::OpFirst) && !started_q) || (op_i == swg_pkg::OpEmit);
  assign buf_wdata = (op_i == swg_pkg::OpFirst) ? first_q : img_letter;

  always_comb begin
    if (op_i == swg_pkg::OpDrain) begin
      buf_raddr = drain_load ? k_inc[swg_pkg::BufAw-1:0] : k_q[swg_pkg::BufAw-1:0];
    end else begin
      buf_raddr = '0;
    end
  end

  swg_ram #(
    .Width (swg_pkg::EntryW),
    .Depth (swg_pkg::StackDepth)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (sp_q[swg_pkg::StackAw-1:0]),
    .wdata_i (stk_wdata),
    .raddr_i (sp_dec[swg_pkg::StackAw-1:0]),
    .rdata_o (stk_rdata)
  );

  swg_ram #(
    .Width (2),
    .Depth (swg_pkg::MaxLetters)
  ) u_letters (
    .clk_i   (clk_i),
    .we_i    (buf_we),
    .waddr_i (gen_q[swg_pkg::BufAw-1:0]),
    .wdata_i (buf_wdata),
    .raddr_i (buf_raddr),
    .rdata_o (buf_rdata)
  );

  always_comb begin
    first_d      = first_q;
    rules_d      = rules_q;
    started_d    = started_q;
    a_d          = a_q;
    i_d          = i_q;
    sp_d         = sp_q;
    lvl_d        = lvl_q;
    ovf_d        = ovf_q;
    cnt_d        = cnt_q;
    gen_d        = gen_q;
    k_d          = k_q;
    out_valid_d  = out_valid_q && !m_axis_tready;
    out_letter_d = out_letter_q;
    out_last_d   = out_last_q;
    out_ovf_d    = out_ovf_q;

    unique case (op_i)
      swg_pkg::OpAccept: begin
        if (s_axis_tvalid) begin
          cnt_d = count_sat;
          gen_d = '0;
        end
      end
      swg_pkg::OpFirst: begin
        if (!started_q) begin
          gen_d     = 7'd1;
          started_d = 1'b1;
        end
      end
      swg_pkg::OpEmit: begin
        i_d   = i_inc;
        gen_d = gen_inc;
      end
      swg_pkg::OpPop: begin
        sp_d  = sp_dec;
        lvl_d = lvl_q + 7'd1;
      end
      swg_pkg::OpLoad: begin
        a_d = stk_rdata[1:0];
        i_d = {1'b0, stk_rdata[4:2]} + 4'd1;
      end
      swg_pkg::OpRoot: begin
        a_d   = first_q;
        i_d   = 4'd1;
        lvl_d = lvl_q + 7'd1;
      end
      swg_pkg::OpPush: begin
        if (sp_q < SpFull) begin
          sp_d = sp_q + 7'd1;
        end else begin
          ovf_d = 1'b1;
        end
        a_d   = img_letter;
        i_d   = '0;
        lvl_d = lvl_q - 7'd1;
      end
      swg_pkg::OpDrainInit: begin
        k_d = '0;
      end
      swg_pkg::OpDrain: begin
        if (drain_load) begin
          out_valid_d  = 1'b1;
          out_letter_d = buf_rdata;
          out_last_d   = (k_inc == cnt_q);
          out_ovf_d    = ovf_q;
          k_d          = k_inc;
        end
      end
      default: ;
    endcase

    if (cfg_we_i) begin
      unique case (cfg_index_i)
        swg_pkg::CfgFirstLetter: begin
          first_d = cfg_data_i[1:0];
          if (!started_q) begin
            a_d = cfg_data_i[1:0];
          end
        end
        swg_pkg::CfgRuleZero:  rules_d[0] = cfg_data_i;
        swg_pkg::CfgRuleOne:   rules_d[1] = cfg_data_i;
        swg_pkg::CfgRuleTwo:   rules_d[2] = cfg_data_i;
        swg_pkg::CfgRuleThree: rules_d[3] = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q     <= '0;
      rules_q     <= '{default: '0};
      started_q   <= 1'b0;
      a_q         <= '0;
      i_q         <= 4'd1;
      sp_q        <= '0;
      lvl_q       <= '0;
      ovf_q       <= 1'b0;
      cnt_q       <= '0;
      gen_q       <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      first_q     <= first_d;
      rules_q     <= rules_d;
      started_q   <= started_d;
      a_q         <= a_d;
      i_q         <= i_d;
      sp_q        <= sp_d;
      lvl_q       <= lvl_d;
      ovf_q       <= ovf_d;
      cnt_q       <= cnt_d;
      gen_q       <= gen_d;
      k_q         <= k_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_letter_q <= out_letter_d;
    out_last_q   <= out_last_d;
    out_ovf_q    <= out_ovf_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'd0, out_ovf_q, out_letter_q};
  assign m_axis_tlast  = out_last_q;

endmodule
